>>> sv/ccpi_pkg.sv
// Shared types, codes and helpers for the class constant pool indexer.
package ccpi_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int CP_AW = $clog2(MAX_ENTRIES);
    localparam logic [16:0] MAX_CNT = 17'(MAX_ENTRIES);
    localparam int MEM_W = 56;

    localparam logic [2:0] ST_FOUND   = 3'd0;
    localparam logic [2:0] ST_BAD_IDX = 3'd1;
    localparam logic [2:0] ST_PARSED  = 3'd2;
    localparam logic [2:0] ST_BAD_TAG = 3'd3;
    localparam logic [2:0] ST_TOO_BIG = 3'd4;

    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_LONG    = 8'd5;
    localparam logic [7:0] TAG_DOUBLE  = 8'd6;
    localparam logic [7:0] TAG_CLASS   = 8'd7;
    localparam logic [7:0] TAG_STRING  = 8'd8;
    localparam logic [7:0] TAG_FIELD   = 8'd9;
    localparam logic [7:0] TAG_METHOD  = 8'd10;
    localparam logic [7:0] TAG_IMETHOD = 8'd11;
    localparam logic [7:0] TAG_NAT     = 8'd12;

    localparam logic [2:0] MODE_NAME_OF = 3'd1;
    localparam logic [2:0] MODE_MCLASS  = 3'd2;
    localparam logic [2:0] MODE_NAME    = 3'd3;
    localparam logic [2:0] MODE_DESC    = 3'd4;

    localparam logic [15:0] POS_COUNT_HI = 16'd8;
    localparam logic [15:0] POS_COUNT_LO = 16'd9;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_TAG    = 7'b0000100,
        PH_ULEN   = 7'b0001000,
        PH_BODY   = 7'b0010000,
        PH_DONE   = 7'b0100000,
        PH_HALT   = 7'b1000000
    } t_phase;

    typedef enum logic [4:0] {
        CH_FINAL  = 5'b00001,
        CH_NAME   = 5'b00010,
        CH_MCLASS = 5'b00100,
        CH_MEMBER = 5'b01000,
        CH_NAT    = 5'b10000
    } t_chain;

    typedef struct packed {
        logic capture;
        logic byte_step;
        logic long_wr;
        logic check;
        logic eval;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic byte_res;
        logic byte_long;
        logic has_res;
        logic idx_ok;
        logic hop;
    } t_sts;

    function automatic logic [3:0] body_length(input logic [7:0] t);
        logic [3:0] len;
        len = 4'd0;
        unique case (t)
            8'd1, 8'd7, 8'd8, 8'd16:                         len = 4'd2;
            8'd15:                                           len = 4'd3;
            8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd18:    len = 4'd4;
            8'd5, 8'd6:                                      len = 4'd8;
            default:                                         len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic is_member(input logic [7:0] t);
        return (t == TAG_FIELD) || (t == TAG_METHOD) || (t == TAG_IMETHOD);
    endfunction

endpackage

>>> sv/ccpi_ctrl.sv
// Sequencer for byte parsing, table lookups and result hand-off.
module ccpi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_kind,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  ccpi_pkg::t_sts i_sts,
    output ccpi_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import ccpi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_BYTE  = 6'b000010,
        S_LONG2 = 6'b000100,
        S_CHECK = 6'b001000,
        S_EVAL  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   out_free;

    assign out_free   = !i_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_valid;
        o_cmd.byte_step = (r_state == S_BYTE);
        o_cmd.long_wr   = (r_state == S_LONG2);
        o_cmd.check     = (r_state == S_CHECK);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.load_out  = (r_state == S_OUT) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = i_kind ? S_CHECK : S_BYTE;
            end
            S_BYTE: begin
                if (i_sts.byte_long)     n_state = S_LONG2;
                else if (i_sts.byte_res) n_state = S_OUT;
                else                     n_state = S_IDLE;
            end
            S_LONG2: n_state = i_sts.has_res ? S_OUT : S_IDLE;
            S_CHECK: n_state = i_sts.idx_ok ? S_EVAL : S_OUT;
            S_EVAL:  n_state = i_sts.hop ? S_CHECK : S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> sv/ccpi_dpath.sv
// Parse state, entry table, lookup chain and result registers.
module ccpi_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ccpi_pkg::t_cmd i_cmd,
    input  logic           i_out_stall,
    input  logic           i_kind,
    input  logic [7:0]     i_data_byte,
    input  logic           i_start_of_file,
    input  logic [15:0]    i_entry_number,
    input  logic [2:0]     i_lookup_mode,
    output ccpi_pkg::t_sts o_sts,
    output logic           o_valid,
    output logic [2:0]     o_status,
    output logic [7:0]     o_tag,
    output logic [15:0]    o_first_word,
    output logic [15:0]    o_second_word,
    output logic [15:0]    o_byte_offset,
    output logic [15:0]    o_resolved_entry,
    output logic [15:0]    o_pool_entries
);
    import ccpi_pkg::*;

    // captured item
    logic        r_sof;
    logic [7:0]  r_byte;
    logic        r_desc;

    // parse state
    t_phase      r_phase, n_phase, e_ph;
    logic [15:0] r_pos, n_pos, e_pos;
    logic [15:0] r_cnt, n_cnt, e_cnt;
    logic [15:0] r_slot, n_slot, e_slot;
    logic [15:0] r_rem, n_rem, e_rem;
    logic [7:0]  r_ptag, n_ptag;
    logic [31:0] r_pwords, n_pwords, words_upd;
    logic [15:0] r_poff, n_poff;

    logic [15:0] k, rem_dec, cnt_lo;
    logic [3:0]  blen;
    logic [16:0] nxt1, nxt;
    logic        do_commit, wr_en, l2_need, b_res;
    logic [2:0]  b_status;
    logic [7:0]  b_tag;
    logic [15:0] b_off, b_ent, b_cnt;

    logic [CP_AW-1:0] r_l2addr;
    logic             r_has_res;

    // entry table: {tag, first word, second word, offset}
    logic [MEM_W-1:0] r_mem [MAX_ENTRIES];
    logic [MEM_W-1:0] r_rd;
    logic             mem_we;
    logic [CP_AW-1:0] mem_wa;
    logic [MEM_W-1:0] mem_wd;

    // lookup chain
    logic [15:0] r_cur;
    t_chain      r_ch, ev_next;
    logic        ev_hop, ev_second, tag_ok, idx_ok;
    logic [7:0]  rd_tag;
    logic [31:0] rd_words;
    logic [15:0] rd_off;

    // pending result
    logic [2:0]  r_rs;
    logic [7:0]  r_rt;
    logic [15:0] r_rw1, r_rw2, r_roff, r_rent, r_rcnt;

    logic        r_ov;

    assign e_ph   = r_sof ? PH_HEADER : r_phase;
    assign e_pos  = r_sof ? 16'd0 : r_pos;
    assign e_cnt  = r_sof ? 16'd0 : r_cnt;
    assign e_slot = r_sof ? 16'd0 : r_slot;
    assign e_rem  = r_sof ? 16'd0 : r_rem;

    assign k       = e_pos - r_poff;
    assign rem_dec = e_rem - 16'd1;
    assign blen    = body_length(r_byte);
    assign cnt_lo  = e_cnt | {8'd0, r_byte};

    always_comb begin
        words_upd = r_pwords;
        unique case (k)
            16'd1:   words_upd[31:24] = r_pwords[31:24] | r_byte;
            16'd2:   words_upd[23:16] = r_pwords[23:16] | r_byte;
            16'd3:   words_upd[15:8]  = r_pwords[15:8]  | r_byte;
            16'd4:   words_upd[7:0]   = r_pwords[7:0]   | r_byte;
            default: words_upd = r_pwords;
        endcase
    end

    always_comb begin
        n_phase   = e_ph;
        n_pos     = (e_ph == PH_IDLE) ? e_pos : e_pos + 16'd1;
        n_cnt     = e_cnt;
        n_slot    = e_slot;
        n_rem     = e_rem;
        n_ptag    = r_ptag;
        n_pwords  = r_pwords;
        n_poff    = r_poff;
        do_commit = 1'b0;
        b_res     = 1'b0;
        b_status  = ST_PARSED;
        b_tag     = 8'd0;
        b_off     = 16'd0;
        b_ent     = 16'd0;
        b_cnt     = 16'd0;
        wr_en     = 1'b0;
        l2_need   = 1'b0;
        nxt1      = {1'b0, e_slot} + 17'd1;
        nxt       = nxt1;
        unique case (e_ph)
            PH_HEADER: begin
                if (e_pos == POS_COUNT_HI) begin
                    n_cnt = {r_byte, 8'd0};
                end else if (e_pos == POS_COUNT_LO) begin
                    n_cnt = cnt_lo;
                    if ({1'b0, cnt_lo} > MAX_CNT) begin
                        n_phase  = PH_HALT;
                        b_res    = 1'b1;
                        b_status = ST_TOO_BIG;
                        b_cnt    = cnt_lo;
                    end else if (cnt_lo <= 16'd1) begin
                        n_slot   = cnt_lo;
                        n_phase  = PH_DONE;
                        b_res    = 1'b1;
                        b_status = ST_PARSED;
                        b_cnt    = cnt_lo;
                    end else begin
                        n_slot  = 16'd1;
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                n_rem = {12'd0, blen};
                if (blen == 4'd0) begin
                    n_phase  = PH_HALT;
                    b_res    = 1'b1;
                    b_status = ST_BAD_TAG;
                    b_tag    = r_byte;
                    b_off    = e_pos;
                    b_ent    = e_slot;
                end else begin
                    n_ptag   = r_byte;
                    n_pwords = 32'd0;
                    n_poff   = e_pos;
                    n_phase  = (r_byte == TAG_UTF8) ? PH_ULEN : PH_BODY;
                end
            end
            PH_ULEN, PH_BODY: begin
                n_pwords = words_upd;
                n_rem    = rem_dec;
                if (rem_dec == 16'd0) begin
                    if (e_ph == PH_ULEN) begin
                        n_rem = words_upd[31:16];
                        if (words_upd[31:16] == 16'd0) do_commit = 1'b1;
                        else                           n_phase = PH_BODY;
                    end else begin
                        do_commit = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (do_commit) begin
            wr_en = ({1'b0, e_slot} < MAX_CNT);
            if ((r_ptag == TAG_LONG) || (r_ptag == TAG_DOUBLE)) begin
                l2_need = (nxt1 < {1'b0, e_cnt}) && (nxt1 < MAX_CNT);
                nxt     = nxt1 + 17'd1;
            end
            if (nxt >= {1'b0, e_cnt}) begin
                n_slot   = e_cnt;
                n_phase  = PH_DONE;
                b_res    = 1'b1;
                b_status = ST_PARSED;
                b_cnt    = e_cnt;
            end else begin
                n_slot  = nxt[15:0];
                n_phase = PH_TAG;
            end
        end
    end

    assign mem_we = (i_cmd.byte_step && wr_en) || i_cmd.long_wr;
    assign mem_wa = i_cmd.long_wr ? r_l2addr : e_slot[CP_AW-1:0];
    assign mem_wd = i_cmd.long_wr ? '0 : {r_ptag, n_pwords, r_poff};

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (i_cmd.check) r_rd <= r_mem[r_cur[CP_AW-1:0]];
    end

    assign rd_tag   = r_rd[55:48];
    assign rd_words = r_rd[47:16];
    assign rd_off   = r_rd[15:0];
    assign tag_ok   = (rd_tag != 8'd0);
    assign idx_ok   = (r_cur != 16'd0) && (r_cur < r_slot);

    always_comb begin
        ev_hop    = 1'b0;
        ev_second = 1'b0;
        ev_next   = CH_FINAL;
        unique case (r_ch)
            CH_NAME: begin
                ev_hop = (rd_tag == TAG_CLASS) || (rd_tag == TAG_STRING);
            end
            CH_MCLASS: begin
                ev_hop  = is_member(rd_tag);
                ev_next = CH_NAME;
            end
            CH_MEMBER: begin
                if (is_member(rd_tag)) begin
                    ev_hop    = 1'b1;
                    ev_second = 1'b1;
                    ev_next   = CH_NAT;
                end else if (rd_tag == TAG_NAT) begin
                    ev_hop    = 1'b1;
                    ev_second = r_desc;
                    ev_next   = CH_NAME;
                end
            end
            CH_NAT: begin
                // the referenced entry is taken as NameAndType unchecked
                ev_hop    = 1'b1;
                ev_second = r_desc;
                ev_next   = CH_NAME;
            end
            default: ev_hop = 1'b0;
        endcase
    end

    always_comb begin
        o_sts           = '0;
        o_sts.byte_res  = b_res;
        o_sts.byte_long = l2_need;
        o_sts.has_res   = r_has_res;
        o_sts.idx_ok    = idx_ok;
        o_sts.hop       = tag_ok && ev_hop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= 16'd0;
            r_cnt       <= 16'd0;
            r_slot      <= 16'd0;
            r_rem       <= 16'd0;
            r_ptag      <= 8'd0;
            r_pwords    <= 32'd0;
            r_poff      <= 16'd0;
            r_sof       <= 1'b0;
            r_has_res   <= 1'b0;
            r_ov        <= 1'b0;
            r_ch        <= CH_FINAL;
        end else begin
            if (i_cmd.capture) begin
                r_sof  <= !i_kind && i_start_of_file;
                r_byte <= i_data_byte;
                r_cur  <= i_entry_number;
                r_desc <= (i_lookup_mode == MODE_DESC);
                if (i_lookup_mode == MODE_NAME_OF)     r_ch <= CH_NAME;
                else if (i_lookup_mode == MODE_MCLASS) r_ch <= CH_MCLASS;
                else if ((i_lookup_mode == MODE_NAME) || (i_lookup_mode == MODE_DESC))
                    r_ch <= CH_MEMBER;
                else                                   r_ch <= CH_FINAL;
            end
            if (i_cmd.byte_step) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_cnt       <= n_cnt;
                r_slot      <= n_slot;
                r_rem       <= n_rem;
                r_ptag      <= n_ptag;
                r_pwords    <= n_pwords;
                r_poff      <= n_poff;
                r_sof       <= 1'b0;
                r_has_res   <= b_res;
                r_l2addr    <= nxt1[CP_AW-1:0];
                r_rs        <= b_status;
                r_rt        <= b_tag;
                r_rw1       <= 16'd0;
                r_rw2       <= 16'd0;
                r_roff      <= b_off;
                r_rent      <= b_ent;
                r_rcnt      <= b_cnt;
            end
            if (i_cmd.check && !idx_ok) begin
                r_rs   <= ST_BAD_IDX;
                r_rt   <= 8'd0;
                r_rw1  <= 16'd0;
                r_rw2  <= 16'd0;
                r_roff <= 16'd0;
                r_rent <= r_cur;
                r_rcnt <= 16'd0;
            end
            if (i_cmd.eval) begin
                if (!tag_ok) begin
                    r_rs   <= ST_BAD_IDX;
                    r_rt   <= 8'd0;
                    r_rw1  <= 16'd0;
                    r_rw2  <= 16'd0;
                    r_roff <= 16'd0;
                    r_rent <= r_cur;
                    r_rcnt <= 16'd0;
                end else if (ev_hop) begin
                    r_cur <= ev_second ? rd_words[15:0] : rd_words[31:16];
                    r_ch  <= ev_next;
                end else begin
                    r_rs   <= ST_FOUND;
                    r_rt   <= rd_tag;
                    r_rw1  <= rd_words[31:16];
                    r_rw2  <= rd_words[15:0];
                    r_roff <= rd_off;
                    r_rent <= r_cur;
                    r_rcnt <= 16'd0;
                end
            end
            if (i_cmd.load_out)  r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status         <= r_rs;
            o_tag            <= r_rt;
            o_first_word     <= r_rw1;
            o_second_word    <= r_rw2;
            o_byte_offset    <= r_roff;
            o_resolved_entry <= r_rent;
            o_pool_entries   <= r_rcnt;
        end
    end

    assign o_valid = r_ov;

endmodule

>>> sv/class_constant_pool_indexer.sv
// Top level of the class constant pool indexer.
//   channel | direction | handshake           | payload
//   input   | in        | i_valid / o_stall   | kind, data_byte, start_of_file, entry_number, lookup_mode
//   output  | out       | o_valid / i_stall   | status, tag, words, byte_offset, resolved_entry, pool_entries
// A file byte goes from idle to the byte step, then to the second-slot clear when a Long or
// Double needs it, and to the output hand-off when it gives a result.
// A lookup checks the index, then evaluates one registered read of the single-port entry table
// per step along a chain (up to 4 reads), and then hands the result to the output register.
// Reset is synchronous; the entry table is not cleared, only entries below the
// current slot are ever used.
// A stalled result holds in the output register while the next item is taken.
module class_constant_pool_indexer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic [15:0] i_entry_number,
    input  logic [2:0]  i_lookup_mode,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_tag,
    output logic [15:0] o_first_word,
    output logic [15:0] o_second_word,
    output logic [15:0] o_byte_offset,
    output logic [15:0] o_resolved_entry,
    output logic [15:0] o_pool_entries
);
    import ccpi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ccpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_kind      (i_kind),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_stall)
    );

    ccpi_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_out_stall      (i_stall),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_start_of_file  (i_start_of_file),
        .i_entry_number   (i_entry_number),
        .i_lookup_mode    (i_lookup_mode),
        .o_sts            (sts),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_tag            (o_tag),
        .o_first_word     (o_first_word),
        .o_second_word    (o_second_word),
        .o_byte_offset    (o_byte_offset),
        .o_resolved_entry (o_resolved_entry),
        .o_pool_entries   (o_pool_entries)
    );

endmodule

>>> sv/ccpi_checker.sv
// Port-level checks for the class constant pool indexer, bound to the top level.
module ccpi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [7:0]  o_tag,
    input logic [15:0] o_first_word,
    input logic [15:0] o_second_word,
    input logic [15:0] o_byte_offset,
    input logic [15:0] o_resolved_entry,
    input logic [15:0] o_pool_entries
);
    import ccpi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_resolved_entry))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("item taken while previous item in flight");

    a_bad_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD_IDX) |-> (o_tag == 8'd0) && (o_first_word == 16'd0)
            && (o_second_word == 16'd0) && (o_byte_offset == 16'd0)
            && (o_pool_entries == 16'd0))
        else $error("invalid-index result carries entry data");

    a_too_big: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_TOO_BIG) |->
            ({1'b0, o_pool_entries} > MAX_CNT) && (o_resolved_entry == 16'd0))
        else $error("oversize pool report inconsistent");

endmodule

bind class_constant_pool_indexer ccpi_checker u_ccpi_checker (.*);
